>>> hw/rtl/tgdt_pkg.sv
`default_nettype none
package tgdt_pkg;

   localparam int DELTA_W     = 24;
   localparam int SUM_W       = 32;
   localparam int SCALE_W     = 16;
   localparam int ROT_THR_W   = 23;
   localparam int SCALE_THR_W = 12;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 23;
   localparam int MASK_W      = 8;

   localparam logic [1:0] MODE_BEGIN  = 2'd0;
   localparam logic [1:0] MODE_UPDATE = 2'd1;
   localparam logic [1:0] MODE_CANCEL = 2'd2;
   localparam logic [1:0] MODE_END    = 2'd3;

   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_HOLD  = 2'd1;
   localparam logic [1:0] KIND_PINCH = 2'd2;
   localparam logic [1:0] KIND_SWIPE = 2'd3;

   localparam logic [1:0] STATUS_OK           = 2'd0;
   localparam logic [1:0] STATUS_HOLD_IGNORED = 2'd1;
   localparam logic [1:0] STATUS_NOT_TRACKING = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROTATION_THRESHOLD = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_THRESHOLD    = 1'd1;

   localparam logic [ROT_THR_W-1:0]   ROT_THR_RESET   = 23'd1280;
   localparam logic [SCALE_THR_W-1:0] SCALE_THR_RESET = 12'd410;
   localparam logic [SCALE_W-1:0]     SCALE_ONE       = 16'd4096;

   localparam int DIR_UP       = 0;
   localparam int DIR_DOWN     = 1;
   localparam int DIR_LEFT     = 2;
   localparam int DIR_RIGHT    = 3;
   localparam int DIR_INWARD   = 4;
   localparam int DIR_OUTWARD  = 5;
   localparam int DIR_CW       = 6;
   localparam int DIR_CCW      = 7;

   typedef struct packed {
      logic [1:0]               kind;
      logic [3:0]               fingers;
      logic signed [SUM_W-1:0]  sum_x;
      logic signed [SUM_W-1:0]  sum_y;
      logic [SCALE_W-1:0]       scale;
      logic signed [SUM_W-1:0]  sum_rotation;
   } tgdt_state_type;

   typedef struct packed {
      logic [ROT_THR_W-1:0]   rotation_threshold;
      logic [SCALE_THR_W-1:0] scale_threshold;
   } tgdt_cfg_type;

endpackage
`default_nettype wire

>>> hw/rtl/tgdt_if.sv
`default_nettype none
interface tgdt_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          mode;
   logic [1:0]                          gesture_kind;
   logic [3:0]                          finger_count;
   logic signed [tgdt_pkg::DELTA_W-1:0] delta_x;
   logic signed [tgdt_pkg::DELTA_W-1:0] delta_y;
   logic [tgdt_pkg::SCALE_W-1:0]        scale_now;
   logic signed [tgdt_pkg::DELTA_W-1:0] rotation_delta;

   modport source (output valid, mode, gesture_kind, finger_count, delta_x, delta_y,
                   scale_now, rotation_delta, input ready);
   modport sink (input valid, mode, gesture_kind, finger_count, delta_x, delta_y,
                 scale_now, rotation_delta, output ready);
endinterface

interface tgdt_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  tracked_kind;
   logic                        gesture_done;
   logic [1:0]                  done_kind;
   logic [3:0]                  done_fingers;
   logic [tgdt_pkg::MASK_W-1:0] direction_mask;
   logic [1:0]                  event_status;

   modport source (output valid, tracked_kind, gesture_done, done_kind, done_fingers,
                   direction_mask, event_status, input ready);
   modport sink (input valid, tracked_kind, gesture_done, done_kind, done_fingers,
                 direction_mask, event_status, output ready);
endinterface

interface tgdt_csr_if;
   logic                             valid;
   logic                             ready;
   logic [tgdt_pkg::CSR_INDEX_W-1:0] index;
   logic [tgdt_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/tgdt_classify.sv
`default_nettype none
module tgdt_classify (
   input  tgdt_pkg::tgdt_state_type     state,
   input  tgdt_pkg::tgdt_cfg_type       cfg,
   output logic [tgdt_pkg::MASK_W-1:0]  direction_mask
);

   logic signed [tgdt_pkg::SUM_W:0] x_ext;
   logic signed [tgdt_pkg::SUM_W:0] y_ext;
   logic signed [tgdt_pkg::SUM_W:0] rot_ext;
   logic signed [tgdt_pkg::SUM_W:0] thr_ext;
   logic [tgdt_pkg::SUM_W:0]        abs_x;
   logic [tgdt_pkg::SUM_W:0]        abs_y;
   logic [tgdt_pkg::SCALE_W:0]      scale_ext;
   logic [tgdt_pkg::SCALE_W:0]      scale_high;
   logic [tgdt_pkg::SCALE_W:0]      scale_low;
   logic                            x_pos;
   logic                            y_pos;

   always_comb begin
      x_ext   = {state.sum_x[tgdt_pkg::SUM_W-1], state.sum_x};
      y_ext   = {state.sum_y[tgdt_pkg::SUM_W-1], state.sum_y};
      rot_ext = {state.sum_rotation[tgdt_pkg::SUM_W-1], state.sum_rotation};
      thr_ext = $signed({{(tgdt_pkg::SUM_W + 1 - tgdt_pkg::ROT_THR_W){1'b0}},
                         cfg.rotation_threshold});
      abs_x   = x_ext[tgdt_pkg::SUM_W] ? $unsigned(-x_ext) : $unsigned(x_ext);
      abs_y   = y_ext[tgdt_pkg::SUM_W] ? $unsigned(-y_ext) : $unsigned(y_ext);
      x_pos   = !state.sum_x[tgdt_pkg::SUM_W-1] && (|state.sum_x);
      y_pos   = !state.sum_y[tgdt_pkg::SUM_W-1] && (|state.sum_y);

      scale_ext  = {1'b0, state.scale};
      scale_high = {1'b0, tgdt_pkg::SCALE_ONE} + (tgdt_pkg::SCALE_W + 1)'(cfg.scale_threshold);
      scale_low  = {1'b0, tgdt_pkg::SCALE_ONE} - (tgdt_pkg::SCALE_W + 1)'(cfg.scale_threshold);

      direction_mask = '0;
      if (state.kind == tgdt_pkg::KIND_PINCH) begin
         direction_mask[tgdt_pkg::DIR_CW]      = rot_ext > thr_ext;
         direction_mask[tgdt_pkg::DIR_CCW]     = rot_ext < -thr_ext;
         direction_mask[tgdt_pkg::DIR_OUTWARD] = scale_ext > scale_high;
         direction_mask[tgdt_pkg::DIR_INWARD]  = scale_ext < scale_low;
      end
      if (state.kind == tgdt_pkg::KIND_PINCH || state.kind == tgdt_pkg::KIND_SWIPE) begin
         if (abs_x > abs_y) begin
            if (x_pos) begin
               direction_mask[tgdt_pkg::DIR_RIGHT] = 1'b1;
            end else begin
               direction_mask[tgdt_pkg::DIR_LEFT] = 1'b1;
            end
         end else if (y_pos) begin
            direction_mask[tgdt_pkg::DIR_DOWN] = 1'b1;
         end else begin
            direction_mask[tgdt_pkg::DIR_UP] = 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/touch_gesture_direction_tracker_core.sv
// Pipeline: a request is registered at acceptance, and its response is registered in the
// response register when the request leaves the request register.
// Throughput: one request per cycle while the response side is not stalled; the gesture state
// updates as a request moves from the request register to the response register.
// Reset: synchronous, active high; clears the gesture state, loads the threshold
// reset values and empties both register stages.
`default_nettype none
module touch_gesture_direction_tracker_core (
   input  wire         clock,
   input  wire         reset,
   tgdt_req_if.sink    req_chan,
   tgdt_rsp_if.source  rsp_chan,
   tgdt_csr_if.sink    csr_chan
);

   typedef struct packed {
      logic [1:0]                          mode;
      logic [1:0]                          gesture_kind;
      logic [3:0]                          finger_count;
      logic signed [tgdt_pkg::DELTA_W-1:0] delta_x;
      logic signed [tgdt_pkg::DELTA_W-1:0] delta_y;
      logic [tgdt_pkg::SCALE_W-1:0]        scale_now;
      logic signed [tgdt_pkg::DELTA_W-1:0] rotation_delta;
   } req_type;

   function automatic logic signed [tgdt_pkg::SUM_W-1:0] sat_add(
      input logic signed [tgdt_pkg::SUM_W-1:0]   acc,
      input logic signed [tgdt_pkg::DELTA_W-1:0] d
   );
      logic signed [tgdt_pkg::SUM_W:0] s;
      s = {acc[tgdt_pkg::SUM_W-1], acc}
          + {{(tgdt_pkg::SUM_W + 1 - tgdt_pkg::DELTA_W){d[tgdt_pkg::DELTA_W-1]}}, d};
      if (s[tgdt_pkg::SUM_W] != s[tgdt_pkg::SUM_W-1]) begin
         return s[tgdt_pkg::SUM_W] ? {1'b1, {(tgdt_pkg::SUM_W - 1){1'b0}}}
                                   : {1'b0, {(tgdt_pkg::SUM_W - 1){1'b1}}};
      end
      return s[tgdt_pkg::SUM_W-1:0];
   endfunction

   logic                         in_valid_ff;
   req_type                      in_ff;
   tgdt_pkg::tgdt_state_type     state_ff;
   tgdt_pkg::tgdt_state_type     state_in;
   tgdt_pkg::tgdt_cfg_type       cfg_ff;
   logic                         out_valid_ff;
   logic [1:0]                   tracked_kind_ff;
   logic                         gesture_done_ff;
   logic [1:0]                   done_kind_ff;
   logic [3:0]                   done_fingers_ff;
   logic [tgdt_pkg::MASK_W-1:0]  direction_mask_ff;
   logic [1:0]                   event_status_ff;

   logic                         advance;
   logic                         fire;
   logic                         done_in;
   logic [1:0]                   done_kind_in;
   logic [3:0]                   done_fingers_in;
   logic [tgdt_pkg::MASK_W-1:0]  direction_mask_in;
   logic [1:0]                   event_status_in;
   logic [tgdt_pkg::MASK_W-1:0]  class_mask;

   tgdt_classify u_classify (
      .state          (state_ff),
      .cfg            (cfg_ff),
      .direction_mask (class_mask)
   );

   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign fire           = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;
   assign csr_chan.ready = 1'b1;

   always_comb begin
      state_in          = state_ff;
      done_in           = 1'b0;
      done_kind_in      = tgdt_pkg::KIND_NONE;
      done_fingers_in   = '0;
      direction_mask_in = '0;
      event_status_in   = tgdt_pkg::STATUS_OK;
      unique case (in_ff.mode)
         tgdt_pkg::MODE_BEGIN: begin
            state_in.kind         = in_ff.gesture_kind;
            state_in.fingers      = in_ff.finger_count;
            state_in.sum_x        = '0;
            state_in.sum_y        = '0;
            state_in.scale        = tgdt_pkg::SCALE_ONE;
            state_in.sum_rotation = '0;
         end
         tgdt_pkg::MODE_UPDATE: begin
            if (state_ff.kind == tgdt_pkg::KIND_HOLD) begin
               event_status_in = tgdt_pkg::STATUS_HOLD_IGNORED;
            end else begin
               state_in.sum_x = sat_add(state_ff.sum_x, in_ff.delta_x);
               state_in.sum_y = sat_add(state_ff.sum_y, in_ff.delta_y);
               if (state_ff.kind == tgdt_pkg::KIND_PINCH) begin
                  state_in.scale        = in_ff.scale_now;
                  state_in.sum_rotation = sat_add(state_ff.sum_rotation, in_ff.rotation_delta);
               end
            end
         end
         tgdt_pkg::MODE_CANCEL: begin
            state_in.kind = tgdt_pkg::KIND_NONE;
         end
         tgdt_pkg::MODE_END: begin
            if (state_ff.kind == tgdt_pkg::KIND_NONE) begin
               event_status_in = tgdt_pkg::STATUS_NOT_TRACKING;
            end else begin
               done_in           = 1'b1;
               done_kind_in      = state_ff.kind;
               done_fingers_in   = state_ff.fingers;
               direction_mask_in = class_mask;
               state_in.kind     = tgdt_pkg::KIND_NONE;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff           <= 1'b0;
         out_valid_ff          <= 1'b0;
         state_ff.kind         <= tgdt_pkg::KIND_NONE;
         state_ff.fingers      <= '0;
         state_ff.sum_x        <= '0;
         state_ff.sum_y        <= '0;
         state_ff.scale        <= tgdt_pkg::SCALE_ONE;
         state_ff.sum_rotation <= '0;
         cfg_ff.rotation_threshold <= tgdt_pkg::ROT_THR_RESET;
         cfg_ff.scale_threshold    <= tgdt_pkg::SCALE_THR_RESET;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         if (fire) begin
            state_ff <= state_in;
         end
         if (csr_chan.valid) begin
            unique case (csr_chan.index)
               tgdt_pkg::CSR_ROTATION_THRESHOLD: begin
                  cfg_ff.rotation_threshold <= csr_chan.data[tgdt_pkg::ROT_THR_W-1:0];
               end
               tgdt_pkg::CSR_SCALE_THRESHOLD: begin
                  cfg_ff.scale_threshold <= csr_chan.data[tgdt_pkg::SCALE_THR_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_ff.mode           <= req_chan.mode;
         in_ff.gesture_kind   <= req_chan.gesture_kind;
         in_ff.finger_count   <= req_chan.finger_count;
         in_ff.delta_x        <= req_chan.delta_x;
         in_ff.delta_y        <= req_chan.delta_y;
         in_ff.scale_now      <= req_chan.scale_now;
         in_ff.rotation_delta <= req_chan.rotation_delta;
      end
      if (fire) begin
         tracked_kind_ff   <= state_in.kind;
         gesture_done_ff   <= done_in;
         done_kind_ff      <= done_kind_in;
         done_fingers_ff   <= done_fingers_in;
         direction_mask_ff <= direction_mask_in;
         event_status_ff   <= event_status_in;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.tracked_kind   = tracked_kind_ff;
   assign rsp_chan.gesture_done   = gesture_done_ff;
   assign rsp_chan.done_kind      = done_kind_ff;
   assign rsp_chan.done_fingers   = done_fingers_ff;
   assign rsp_chan.direction_mask = direction_mask_ff;
   assign rsp_chan.event_status   = event_status_ff;

endmodule
`default_nettype wire
